>>> design/lmb_pkg.sv
// Package with the shared constants, types and codes of the light-mask blit engine.
package lmb_pkg;

  localparam int MaxMaskW  = 256;
  localparam int MaxMaskH  = 256;
  localparam int MaxImageW = 256;
  localparam int MaxImageH = 256;
  localparam int MaskCells = MaxMaskW * MaxMaskH;
  localparam int OpacCells = MaxImageW * MaxImageH;
  localparam int MaskAw    = $clog2(MaskCells);
  localparam int OpacAw    = $clog2(OpacCells);
  localparam int ImgXw     = $clog2(MaxImageW);

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_FILL  = 3'd1,
    OP_DRAW  = 3'd2,
    OP_READ  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_MASK_W  = 3'd0,
    REG_MASK_H  = 3'd1,
    REG_IMAGE_W = 3'd2,
    REG_IMAGE_H = 3'd3,
    REG_CLIP_L  = 3'd4,
    REG_CLIP_T  = 3'd5,
    REG_CLIP_SX = 3'd6,
    REG_CLIP_SY = 3'd7
  } reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_SETUP,
    ST_ROW,
    ST_ROWCHK,
    ST_PIX,
    ST_OPRD,
    ST_MKRD,
    ST_WR,
    ST_RDWAIT,
    ST_RDDONE,
    ST_DONE
  } state_t;

endpackage

>>> design/lmb_ram.sv
// Generic single-port synchronous RAM with a registered read.
module lmb_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // At most one write and one read of the same address each cycle; the read returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/lightmask_blit_engine_unit.sv
// Top level of the light-mask blit engine.
// An operation is taken when start is high and busy is low; busy stays high until its single
// result is shown on read_level, fully_lit and culled with done high for one cycle. The
// receiver cannot stall. Loads and reads show their result after ST_RDWAIT and ST_RDDONE,
// and unused operation codes in the next cycle. A clear sweeps all 65536 mask entries, one
// entry a cycle. The same sweep runs after reset with busy high and gives no result. A fill
// steps each clipped pixel through address, mask read and mask write, with ST_ROW and
// ST_ROWCHK per row. A draw first runs a restoring ratio division per axis, then steps each
// clipped pixel whose sample lies in the image through address, opacity read, mask read and
// mask write, as each memory has a single port, and skips one whose sample does not.
module lightmask_blit_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [2:0]  operation,
  input  logic signed [12:0] dst_x,
  input  logic signed [12:0] dst_y,
  input  logic [11:0] dst_w,
  input  logic [11:0] dst_h,
  input  logic [7:0]  src_x,
  input  logic [7:0]  src_y,
  input  logic [8:0]  src_w,
  input  logic [8:0]  src_h,
  input  logic [1:0]  flip,
  input  logic        blend_or,
  input  logic [7:0]  level,
  output logic [7:0]  read_level,
  output logic        fully_lit,
  output logic        culled,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import lmb_pkg::*;

  // Configuration registers.
  logic [8:0] mask_width, mask_height, image_width, image_height;
  logic [7:0] clip_left, clip_top;
  logic [8:0] clip_span_x, clip_span_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_width <= 9'd256; mask_height <= 9'd256;
      image_width <= 9'd256; image_height <= 9'd256;
      clip_left <= '0; clip_top <= '0;
      clip_span_x <= 9'd256; clip_span_y <= 9'd256;
    end else if (cfg_we) begin
      case (reg_t'(cfg_index))
        REG_MASK_W:  mask_width   <= cfg_data;
        REG_MASK_H:  mask_height  <= cfg_data;
        REG_IMAGE_W: image_width  <= cfg_data;
        REG_IMAGE_H: image_height <= cfg_data;
        REG_CLIP_L:  clip_left    <= cfg_data[7:0];
        REG_CLIP_T:  clip_top     <= cfg_data[7:0];
        REG_CLIP_SX: clip_span_x  <= cfg_data;
        REG_CLIP_SY: clip_span_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes clamped to one and the maximum.
  logic [8:0] mw, mh, iw, ih;
  always_comb begin
    mw = (mask_width == '0) ? 9'd1 : mask_width;
    mh = (mask_height == '0) ? 9'd1 : mask_height;
    iw = (image_width == '0) ? 9'd1 : image_width;
    ih = (image_height == '0) ? 9'd1 : image_height;
    if (mw > 9'(MaxMaskW)) mw = 9'(MaxMaskW);
    if (mh > 9'(MaxMaskH)) mh = 9'(MaxMaskH);
    if (iw > 9'(MaxImageW)) iw = 9'(MaxImageW);
    if (ih > 9'(MaxImageH)) ih = 9'(MaxImageH);
  end

  // Captured item.
  op_t               op;
  logic signed [13:0] dx, dy;
  logic [12:0]       dw, dh;
  logic [7:0]        sx, sy;
  logic [8:0]        sw, sh;
  logic [1:0]        flp;
  logic              keep;
  logic [7:0]        lv;

  state_t state, state_next;

  // Walk registers.
  logic signed [14:0] ex, ey;
  logic [8:0]  x0, x1, y1;
  logic [8:0]  x, y;
  logic [24:0] rw, rh;
  logic [8:0]  py;
  logic        row_ok;
  logic [MaskAw:0] clr_cnt;
  logic [29:0] div_rem;
  logic [24:0] div_q;
  logic [4:0]  div_cnt;
  logic        div_axis;
  logic [7:0]  rlev;
  logic        lit, cul;

  // Span of destination [d0, d1) clipped to [c0, c1) and to the mask size.
  function automatic logic [8:0] clipv(input logic signed [14:0] d,
                                        input logic [9:0] c0, input logic [9:0] c1,
                                        input logic [8:0] m);
    logic signed [14:0] a;
    begin
      a = d;
      if (a < $signed({5'd0, c0})) a = $signed({5'd0, c0});
      if (a > $signed({5'd0, c1})) a = $signed({5'd0, c1});
      if (a > $signed({6'd0, m})) a = $signed({6'd0, m});
      clipv = a[8:0];
    end
  endfunction

  logic [9:0] cl, ct, cr, cb;
  assign cl = {2'b0, clip_left};
  assign ct = {2'b0, clip_top};
  assign cr = cl + {1'b0, clip_span_x};
  assign cb = ct + {1'b0, clip_span_y};

  // Cull test on the captured destination.
  logic signed [14:0] lo_x, hi_x, lo_y, hi_y;
  logic cull_now;
  always_comb begin
    lo_x = (15'(dx) > $signed({5'd0, cl})) ? 15'(dx) : $signed({5'd0, cl});
    hi_x = (ex < $signed({5'd0, cr})) ? ex : $signed({5'd0, cr});
    lo_y = (15'(dy) > $signed({5'd0, ct})) ? 15'(dy) : $signed({5'd0, ct});
    hi_y = (ey < $signed({5'd0, cb})) ? ey : $signed({5'd0, cb});
    cull_now = (dw == '0) || (dh == '0) || (lo_x >= hi_x) || (lo_y >= hi_y);
  end

  // Sample positions for the current row and column.
  logic [37:0] offy, offx;
  logic [25:0] topy, rgtx;
  logic [38:0] pyf, pxf;
  logic        ysk, xsk;
  logic [13:0] ddy, ddx;
  always_comb begin
    ddy = 14'(ey - $signed({6'd0, y}));
    ddx = 14'(ex - $signed({6'd0, x}));
    offy = 38'(ddy) * 38'(rh[24:0]);
    offx = 38'(ddx) * 38'(rw[24:0]);
    topy = 26'({9'd0, ({1'b0, sy} + sh)} << 16);
    rgtx = 26'({9'd0, ({1'b0, sx} + sw)} << 16);
    if (flp[1]) begin
      pyf = 39'({sy, 16'd0}) + 39'(offy); ysk = 1'b0;
    end else begin
      ysk = offy > 38'(topy); pyf = 39'(topy) - 39'(offy);
    end
    if (flp[0]) begin
      pxf = 39'({sx, 16'd0}) + 39'(offx); xsk = 1'b0;
    end else begin
      xsk = offx > 38'(rgtx); pxf = 39'(rgtx) - 39'(offx);
    end
  end
  logic [22:0] px_i, py_i;
  assign px_i = pxf[38:16];
  assign py_i = pyf[38:16];
  logic px_ok;
  assign px_ok = !xsk && (px_i < 23'(iw));

  // Memory ports.
  logic             mk_we, op_we;
  logic [MaskAw-1:0] mk_addr;
  logic [OpacAw-1:0] op_addr;
  logic [7:0]       mk_wdata, mk_rdata;
  logic [0:0]       op_wdata, op_rdata;
  logic [17:0]      row_base;
  assign row_base = 18'(y) * 18'(mw);

  lmb_ram #(.Width(8), .Depth(MaskCells)) u_mask (
    .clk(clk), .we(mk_we), .addr(mk_addr), .wdata(mk_wdata), .rdata(mk_rdata));
  lmb_ram #(.Width(1), .Depth(OpacCells)) u_opac (
    .clk(clk), .we(op_we), .addr(op_addr), .wdata(op_wdata), .rdata(op_rdata));

  // Read pixel address checks.
  logic rd_in;
  logic [17:0] rd_idx;
  assign rd_in  = (dx >= 0) && (dy >= 0) && (dx < $signed({5'd0, mw})) &&
                  (dy < $signed({5'd0, mh}));
  assign rd_idx = 18'(dy[8:0]) * 18'(mw) + 18'(dx[8:0]);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) begin
        case (op_t'(operation))
          OP_LOAD, OP_READ: state_next = ST_RDWAIT;
          OP_FILL:  state_next = ST_SETUP;
          OP_DRAW:  state_next = ST_SETUP;
          OP_CLEAR: state_next = ST_CLEAR;
          default:  state_next = ST_DONE;
        endcase
      end
      // The sweep after reset is not an item and gives no result.
      ST_CLEAR:  if (clr_cnt == (MaskAw+1)'(MaskCells - 1)) begin
        state_next = (op == OP_CLEAR) ? ST_DONE : ST_IDLE;
      end
      ST_SETUP:  begin
        if (op == OP_DRAW && cull_now) state_next = ST_DONE;
        else if (op == OP_DRAW) state_next = ST_DIV;
        else state_next = ST_ROW;
      end
      ST_DIV:    if (div_cnt == 5'd0 && div_axis) state_next = ST_ROW;
      ST_ROW:    state_next = (y >= y1) ? ST_DONE : ST_ROWCHK;
      ST_ROWCHK: state_next = ST_PIX;
      ST_PIX: begin
        if (x >= x1 || (op == OP_DRAW && !row_ok)) state_next = ST_ROW;
        else if (op == OP_DRAW) state_next = px_ok ? ST_OPRD : ST_PIX;
        else state_next = ST_MKRD;
      end
      ST_OPRD:   state_next = ST_MKRD;
      ST_MKRD:   state_next = ST_WR;
      ST_WR:     state_next = ST_PIX;
      ST_RDWAIT: state_next = ST_RDDONE;
      ST_RDDONE: state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    mk_we = 1'b0; op_we = 1'b0;
    mk_addr = MaskAw'(18'(row_base) + 18'(x));
    mk_wdata = lv;
    op_addr = OpacAw'({py[ImgXw-1:0], px_i[ImgXw-1:0]});
    op_wdata = 1'(lv == 8'd255);
    case (state)
      ST_CLEAR: begin
        mk_we = 1'b1; mk_wdata = '0; mk_addr = clr_cnt[MaskAw-1:0];
      end
      ST_IDLE: begin
        mk_addr = MaskAw'(rd_idx);
        op_addr = OpacAw'({src_y[ImgXw-1:0], src_x[ImgXw-1:0]});
        op_wdata = 1'(level == 8'd255);
        op_we = start && (op_t'(operation) == OP_LOAD) &&
                ({1'b0, src_x} < iw) && ({1'b0, src_y} < ih);
      end
      // The read pixel comes from the captured coordinates.
      ST_RDWAIT: mk_addr = MaskAw'(rd_idx);
      ST_WR: mk_we = (op != OP_DRAW || op_rdata[0]) && !(keep && mk_rdata == 8'd255);
      default: ;
    endcase
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
    read_level = rlev;
    fully_lit = lit;
    culled = cul;
  end

  // Sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      op <= OP_LOAD;
      clr_cnt <= '0;
      rlev <= '0; lit <= 1'b0; cul <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (start) begin
          op <= op_t'(operation);
          dx <= 14'(dst_x); dy <= 14'(dst_y);
          sx <= src_x; sy <= src_y;
          flp <= flip; keep <= blend_or; lv <= level;
          rlev <= '0; lit <= 1'b0; cul <= 1'b0;
          clr_cnt <= '0;
          // Whole-mask destination applies to a draw only.
          if (op_t'(operation) == OP_DRAW && dst_x == '0 && dst_y == '0 &&
              dst_w == '0 && dst_h == '0) begin
            dw <= 13'(mw); dh <= 13'(mh);
            ex <= 15'(mw); ey <= 15'(mh);
          end else begin
            dw <= {1'b0, dst_w}; dh <= {1'b0, dst_h};
            ex <= 15'(dst_x) + 15'(dst_w);
            ey <= 15'(dst_y) + 15'(dst_h);
          end
          if (src_x == '0 && src_y == '0 && src_w == '0 && src_h == '0) begin
            sw <= iw; sh <= ih;
          end else begin
            sw <= src_w; sh <= src_h;
          end
        end
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_SETUP: begin
          x0 <= clipv(15'(dx), cl, cr, mw);
          x1 <= clipv(ex, cl, cr, mw);
          y  <= clipv(15'(dy), ct, cb, mh);
          y1 <= clipv(ey, ct, cb, mh);
          cul <= (op == OP_DRAW) && cull_now;
          div_axis <= 1'b0; div_cnt <= 5'd24;
          div_rem <= '0; div_q <= {sw, 16'd0};
        end
        ST_DIV: begin
          // Restoring division, one quotient bit a cycle.
          logic [29:0] trial;
          logic [12:0] dv;
          logic [24:0] qn;
          trial = {div_rem[28:0], div_q[24]};
          dv = div_axis ? dh : dw;
          qn = {div_q[23:0], 1'b0};
          if (trial >= 30'(dv)) begin
            trial = trial - 30'(dv); qn[0] = 1'b1;
          end
          if (div_cnt == 5'd0 && !div_axis) begin
            rw <= qn; div_axis <= 1'b1; div_cnt <= 5'd24;
            div_rem <= '0; div_q <= {sh, 16'd0};
          end else begin
            div_rem <= trial;
            div_q <= qn;
            if (div_cnt == 5'd0) rh <= qn;
            else div_cnt <= div_cnt - 1'b1;
          end
        end
        ST_ROW: x <= x0;
        ST_ROWCHK: begin
          py <= py_i[8:0];
          row_ok <= !ysk && (py_i < 23'(ih));
        end
        ST_PIX: begin
          if (x >= x1 || (op == OP_DRAW && !row_ok)) y <= y + 1'b1;
          else if (op == OP_DRAW && !px_ok) x <= x + 1'b1;
        end
        ST_WR: x <= x + 1'b1;
        ST_RDDONE: if (op == OP_READ && rd_in) begin
          rlev <= mk_rdata; lit <= (mk_rdata == 8'd255);
        end
        default: ;
      endcase
    end
  end

endmodule
